>>> hdl/token_bucket_pacer_core_macros.svh
// Assertion macros of the token bucket pacer RTL.
// Stand-alone header; included by token_bucket_pacer_core, which checks its own logic.
`ifndef TOKEN_BUCKET_PACER_CORE_MACROS_SVH
`define TOKEN_BUCKET_PACER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_NXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tbp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and types of the token bucket pacer.
// No dependencies; imported by every module of the block.
package tbp_pkg;

  // Fixed-point and sizing constants.
  localparam int PACKET_BUFFER_BYTES = 2048;
  localparam int TOKEN_FRACTION_BITS = 16;
  localparam int RATE_FRACTION_BITS  = 32;

  // Field and state widths.
  localparam int BPS_W   = 37;
  localparam int NOW_W   = 64;
  localparam int BYTES_W = 16;
  localparam int WAIT_W  = 48;
  localparam int TOKEN_W = 48;
  localparam int RATE_W  = 36;
  localparam int BURST_W = 32;

  // Derived widths of the datapath.
  localparam int RATE_TOKEN_SHIFT = RATE_FRACTION_BITS - TOKEN_FRACTION_BITS;
  localparam int CONV_STEPS       = BPS_W + RATE_FRACTION_BITS;
  localparam int NEED_W           = BYTES_W + TOKEN_FRACTION_BITS;
  localparam int DIV_NUM_W        = NEED_W + RATE_TOKEN_SHIFT;
  localparam int PROD_W           = NOW_W + RATE_W;
  localparam int REFILL_W         = TOKEN_W + 1;
  localparam int SUM_W            = TOKEN_W + 2;

  // Rate conversion divisors: bits per second to bytes per ns, and to burst bytes.
  localparam int BPS_DIV_W = 34;
  localparam logic [BPS_DIV_W-1:0] BITS_PER_NS_DIV = 34'd8000000000;
  localparam int BURST_DIV_W = 8;
  localparam logic [BURST_DIV_W-1:0] BURST_DIVISOR = 8'd80;

  // Rates and limits.
  localparam logic [BPS_W-1:0] DEFAULT_BPS   = 37'd100000000;
  localparam logic [BPS_W-1:0] RESET_MIN_BPS = 37'd1000000;
  localparam logic [BPS_W-1:0] RESET_MAX_BPS = 37'd100000000000;
  localparam logic [BURST_W-1:0] BURST_FLOOR = BURST_W'(PACKET_BUFFER_BYTES * 10);

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_PACING_ENABLED = 2'd0,
    REG_INITIAL_RATE   = 2'd1,
    REG_MIN_RATE       = 2'd2,
    REG_MAX_RATE       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> hdl/token_bucket_pacer_core.sv
`timescale 1ns / 1ps
// Token bucket send pacer: one request at a time; an acquire request returns the
// wait in ns, an update request changes the rate; results leave through an output
// register, so the next request is taken while a result still waits. A request
// with pacing disabled skips the arithmetic. A rate update runs the 69-step
// bit-serial rate conversion. An acquire runs the 36-step shift-add refill
// multiplier, and when it must wait at a nonzero rate, also the 48-step restoring
// divider for the wait time; the first acquire after reset also runs the rate
// conversion. Depends on tbp_pkg, tbp_rate_conv, tbp_refill_mul, tbp_wait_div and
// the assertion macro header.
`include "token_bucket_pacer_core_macros.svh"

module token_bucket_pacer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [tbp_pkg::NOW_W-1:0]       in_now_ns,
  input  logic [tbp_pkg::BYTES_W-1:0]     in_packet_bytes,
  input  logic [tbp_pkg::BPS_W-1:0]       in_new_rate_bps,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tbp_pkg::WAIT_W-1:0]      out_wait_ns,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tbp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tbp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLAMP = 11'b000_0000_0010,
    S_RATE  = 11'b000_0000_0100,
    S_INIT  = 11'b000_0000_1000,
    S_MULGO = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_SUM   = 11'b000_0100_0000,
    S_CAP   = 11'b000_1000_0000,
    S_CHECK = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  // Configuration registers.
  logic             enable_r, enable_nxt;
  logic [BPS_W-1:0] init_bps_r, init_bps_nxt;
  logic [BPS_W-1:0] min_bps_r, min_bps_nxt;
  logic [BPS_W-1:0] max_bps_r, max_bps_nxt;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  // Sequencer and request registers.
  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [NOW_W-1:0]   now_r, now_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [BPS_W-1:0]   nbps_r, nbps_nxt;

  // Pacer state.
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic [TOKEN_W-1:0]  token_r, token_nxt;
  logic [NOW_W-1:0]    last_r, last_nxt;
  logic                initialised_r, initialised_nxt;

  // Working registers.
  logic [REFILL_W-1:0] refill_r, refill_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WAIT_W-1:0]   out_wait_r, out_wait_nxt;

  // Datapath around the serial units.
  logic                conv_start, mul_start, div_start;
  logic [BPS_W-1:0]    conv_bps, init_sel_bps, clamp_lo_bps, clamp_bps;
  logic [RATE_W-1:0]   conv_rate;
  logic [BURST_W-1:0]  conv_burst;
  logic [REFILL_W-1:0] mul_refill;
  logic [WAIT_W-1:0]   div_quo;
  logic [NOW_W-1:0]    elapsed;
  logic [BURST_W-1:0]  burst_floored;
  logic [SUM_W-1:0]    cap;
  logic [NEED_W-1:0]   need;
  logic [TOKEN_W:0]    token_left;
  logic [NEED_W-1:0]   deficit;
  logic                load_out;
  unit_stat_t          conv_stat, mul_stat, div_stat;

  // Configuration writes and reads.
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign pready  = 1'b1;

  always_comb begin
    enable_nxt   = enable_r;
    init_bps_nxt = init_bps_r;
    min_bps_nxt  = min_bps_r;
    max_bps_nxt  = max_bps_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PACING_ENABLED: enable_nxt   = pwdata[0];
        REG_INITIAL_RATE:   init_bps_nxt = pwdata[BPS_W-1:0];
        REG_MIN_RATE:       min_bps_nxt  = pwdata[BPS_W-1:0];
        REG_MAX_RATE:       max_bps_nxt  = pwdata[BPS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PACING_ENABLED: prdata = CFG_DATA_W'(enable_r);
      REG_INITIAL_RATE:   prdata = CFG_DATA_W'(init_bps_r);
      REG_MIN_RATE:       prdata = CFG_DATA_W'(min_bps_r);
      REG_MAX_RATE:       prdata = CFG_DATA_W'(max_bps_r);
    endcase
  end

  // Operand selection for the serial units.
  always_comb begin
    init_sel_bps  = (init_bps_r == '0) ? DEFAULT_BPS : init_bps_r;
    // The min clamp goes first, so max wins when the two cross.
    clamp_lo_bps  = (nbps_r < min_bps_r) ? min_bps_r : nbps_r;
    clamp_bps     = (clamp_lo_bps > max_bps_r) ? max_bps_r : clamp_lo_bps;
    conv_bps      = (state_r == S_CLAMP) ? clamp_bps : init_sel_bps;
    elapsed       = now_r - last_r;
    burst_floored = (burst_r < BURST_FLOOR) ? BURST_FLOOR : burst_r;
    cap           = SUM_W'(burst_r) << TOKEN_FRACTION_BITS;
    need          = NEED_W'(bytes_r) << TOKEN_FRACTION_BITS;
    token_left    = {1'b0, token_r} - (TOKEN_W + 1)'(need);
    deficit       = need - token_r[NEED_W-1:0];
  end

  // Request sequencer.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    now_nxt         = now_r;
    bytes_nxt       = bytes_r;
    nbps_nxt        = nbps_r;
    rate_nxt        = rate_r;
    burst_nxt       = burst_r;
    token_nxt       = token_r;
    last_nxt        = last_r;
    initialised_nxt = initialised_r;
    refill_nxt      = refill_r;
    sum_nxt         = sum_r;
    wait_nxt        = wait_r;
    conv_start      = 1'b0;
    mul_start       = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          now_nxt   = in_now_ns;
          bytes_nxt = in_packet_bytes;
          nbps_nxt  = in_new_rate_bps;
          priority if (!enable_r) begin
            wait_nxt  = '0;
            state_nxt = S_DONE;
          end else if (cmd_t'(in_command) == CMD_UPDATE) begin
            state_nxt = S_CLAMP;
          end else if (!initialised_r) begin
            conv_start = 1'b1;
            state_nxt  = S_RATE;
          end else begin
            state_nxt = S_MULGO;
          end
        end
      end
      S_CLAMP: begin
        conv_start = 1'b1;
        state_nxt  = S_RATE;
      end
      S_RATE: begin
        if (conv_stat.done) begin
          rate_nxt  = conv_rate;
          burst_nxt = conv_burst;
          if (cmd_r == CMD_UPDATE) begin
            wait_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // First acquire: floor the burst, fill the bucket, start the clock.
        burst_nxt       = burst_floored;
        token_nxt       = TOKEN_W'(burst_floored) << TOKEN_FRACTION_BITS;
        last_nxt        = now_r;
        initialised_nxt = 1'b1;
        state_nxt       = S_MULGO;
      end
      S_MULGO: begin
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_stat.done) begin
          refill_nxt = mul_refill;
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = SUM_W'(token_r) + SUM_W'(refill_r);
        last_nxt  = now_r;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        token_nxt = (sum_r > cap) ? cap[TOKEN_W-1:0] : sum_r[TOKEN_W-1:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // A borrow means the tokens fall short of the packet.
        if (!token_left[TOKEN_W]) begin
          token_nxt = token_left[TOKEN_W-1:0];
          wait_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          token_nxt = '0;
          if (rate_r == '0) begin
            wait_nxt  = '1;
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          wait_nxt  = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_wait_nxt  = out_wait_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_wait_nxt  = wait_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      initialised_r <= 1'b0;
      out_valid_r   <= 1'b0;
      enable_r      <= 1'b0;
      init_bps_r    <= DEFAULT_BPS;
      min_bps_r     <= RESET_MIN_BPS;
      max_bps_r     <= RESET_MAX_BPS;
      cmd_r         <= CMD_ACQUIRE;
    end else begin
      state_r       <= state_nxt;
      initialised_r <= initialised_nxt;
      out_valid_r   <= out_valid_nxt;
      enable_r      <= enable_nxt;
      init_bps_r    <= init_bps_nxt;
      min_bps_r     <= min_bps_nxt;
      max_bps_r     <= max_bps_nxt;
      cmd_r         <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    bytes_r    <= bytes_nxt;
    nbps_r     <= nbps_nxt;
    rate_r     <= rate_nxt;
    burst_r    <= burst_nxt;
    token_r    <= token_nxt;
    last_r     <= last_nxt;
    refill_r   <= refill_nxt;
    sum_r      <= sum_nxt;
    wait_r     <= wait_nxt;
    out_wait_r <= out_wait_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_wait_ns = out_wait_r;

  // Serial arithmetic units.
  tbp_rate_conv u_rate_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bps   (conv_bps),
    .rate  (conv_rate),
    .burst (conv_burst),
    .stat  (conv_stat)
  );

  tbp_refill_mul u_refill_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .elapsed (elapsed),
    .rate    (rate_r),
    .refill  (mul_refill),
    .stat    (mul_stat)
  );

  tbp_wait_div u_wait_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .deficit  (deficit),
    .divisor  (rate_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Checks on the sequencer and its units.
  `TBP_ASSERT_NXT(a_init_sticky, clk, rst_n, initialised_r, initialised_r,
                  "initialised cleared")
  `TBP_ASSERT_IMP(a_mul_done_state, clk, rst_n, mul_stat.done, state_r == S_MUL,
                  "stray mul done")
  `TBP_ASSERT_IMP(a_unit_done_state, clk, rst_n, conv_stat.done || div_stat.done,
                  (state_r == S_RATE) || (state_r == S_DIV), "stray unit done")
  `TBP_ASSERT_IMP(a_token_capped, clk, rst_n, state_r == S_CHECK,
                  SUM_W'(token_r) <= cap, "bucket above cap")
  `TBP_ASSERT_IMP(a_wait_acquire, clk, rst_n, load_out && (wait_r != '0),
                  enable_r && (cmd_r == CMD_ACQUIRE), "wait on non-acquire")

endmodule

>>> hdl/tbp_rate_conv.sv
`timescale 1ns / 1ps
// Bit-serial conversion of a bits-per-second rate into bytes per ns and burst bytes.
// Depends on tbp_pkg.
module tbp_rate_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tbp_pkg::BPS_W-1:0]   bps,
  output logic [tbp_pkg::RATE_W-1:0]  rate,
  output logic [tbp_pkg::BURST_W-1:0] burst,
  output tbp_pkg::unit_stat_t         stat
);
  import tbp_pkg::*;

  localparam int CNT_W = $clog2(CONV_STEPS + 1);

  logic [BPS_W-1:0]       num_r, num_nxt;
  logic [BPS_DIV_W-2:0]   rem_r, rem_nxt;
  logic [RATE_W-1:0]      q_r, q_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [BURST_DIV_W-2:0] brem_r, brem_nxt;
  logic [BURST_W-1:0]     bq_r, bq_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic                   bit_in;
  logic [BPS_DIV_W-1:0]   r2, r2_diff;
  logic                   ge;
  logic [BURST_DIV_W-1:0] br2, br2_diff;
  logic                   bge;
  logic                   burst_phase;

  // One restoring step of each division; the burst division sees only the integer bits.
  always_comb begin
    bit_in      = num_r[BPS_W-1];
    r2          = {rem_r, bit_in};
    ge          = (r2 >= BITS_PER_NS_DIV);
    r2_diff     = r2 - BITS_PER_NS_DIV;
    br2         = {brem_r, bit_in};
    bge         = (br2 >= BURST_DIVISOR);
    br2_diff    = br2 - BURST_DIVISOR;
    burst_phase = (cnt_r > CNT_W'(RATE_FRACTION_BITS));

    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    brem_nxt = brem_r;
    bq_nxt   = bq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      num_nxt  = bps;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      brem_nxt = '0;
      bq_nxt   = '0;
      cnt_nxt  = CNT_W'(CONV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[BPS_W-2:0], 1'b0};
      rem_nxt = ge ? r2_diff[BPS_DIV_W-2:0] : r2[BPS_DIV_W-2:0];
      q_nxt   = {q_r[RATE_W-2:0], ge};
      ovf_nxt = ovf_r | q_r[RATE_W-1];
      if (burst_phase) begin
        brem_nxt = bge ? br2_diff[BURST_DIV_W-2:0] : br2[BURST_DIV_W-2:0];
        bq_nxt   = {bq_r[BURST_W-2:0], bge};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    brem_r <= brem_nxt;
    bq_r   <= bq_nxt;
  end

  // The rate saturates once the quotient runs past its width.
  assign rate      = ovf_r ? '1 : q_r;
  assign burst     = bq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/tbp_refill_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier for the bucket refill (elapsed ns times rate).
// Depends on tbp_pkg.
module tbp_refill_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tbp_pkg::NOW_W-1:0]    elapsed,
  input  logic [tbp_pkg::RATE_W-1:0]   rate,
  output logic [tbp_pkg::REFILL_W-1:0] refill,
  output tbp_pkg::unit_stat_t          stat
);
  import tbp_pkg::*;

  localparam int CNT_W = $clog2(RATE_W + 1);

  logic [NOW_W-1:0]  mcand_r, mcand_nxt;
  logic [NOW_W-1:0]  hi_r, hi_nxt;
  logic [RATE_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [NOW_W:0]    psum;
  logic [PROD_W-1:0] product;
  logic              sat;

  // One multiplier bit per cycle, taken from the low end of the product register.
  always_comb begin
    psum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;

    if (start) begin
      mcand_nxt = elapsed;
      hi_nxt    = '0;
      lo_nxt    = rate;
      cnt_nxt   = CNT_W'(RATE_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = psum[NOW_W:1];
      lo_nxt  = {psum[0], lo_r[RATE_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  // Rescale to the token format. Anything at or above one full token word is
  // reported as exactly that much, which is already beyond any bucket cap.
  assign product = {hi_r, lo_r};
  assign sat     = |product[PROD_W-1:RATE_TOKEN_SHIFT+TOKEN_W];
  assign refill  = sat ? {1'b1, {TOKEN_W{1'b0}}}
                       : {1'b0, product[RATE_TOKEN_SHIFT +: TOKEN_W]};

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/tbp_wait_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider that turns a token deficit into a wait time.
// Depends on tbp_pkg.
module tbp_wait_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tbp_pkg::NEED_W-1:0] deficit,
  input  logic [tbp_pkg::RATE_W-1:0] divisor,
  output logic [tbp_pkg::WAIT_W-1:0] quotient,
  output tbp_pkg::unit_stat_t        stat
);
  import tbp_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [RATE_W-1:0]    dvsr_r, dvsr_nxt;
  logic [RATE_W-1:0]    rem_r, rem_nxt;
  logic [WAIT_W-1:0]    q_r, q_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [RATE_W:0]      r2, r2_diff;
  logic                 ge;

  // Numerator is the deficit moved from token to rate fraction bits.
  always_comb begin
    r2      = {rem_r, num_r[DIV_NUM_W-1]};
    ge      = (r2 >= {1'b0, dvsr_r});
    r2_diff = r2 - {1'b0, dvsr_r};

    num_nxt  = num_r;
    dvsr_nxt = dvsr_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      num_nxt  = DIV_NUM_W'(deficit) << RATE_TOKEN_SHIFT;
      dvsr_nxt = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_nxt = ge ? r2_diff[RATE_W-1:0] : r2[RATE_W-1:0];
      q_nxt   = {q_r[WAIT_W-2:0], ge};
      ovf_nxt = ovf_r | q_r[WAIT_W-1];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
  end

  // The wait saturates at its field maximum.
  assign quotient  = ovf_r ? '1 : q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
